// ----- design/c16d_pkg.sv -----
// package: shared widths, codes, result type and crc helper for the frame deframer
`timescale 1ns / 1ps
`default_nettype none
package c16d_pkg;

	localparam int OP_W      = 2;
	localparam int BYTE_W    = 8;
	localparam int KIND_W    = 3;
	localparam int LEN_W     = 16;
	localparam int CRC_W     = 16;
	localparam int TICK_W    = 32;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_W     = 32;

	// input operations
	localparam logic [OP_W-1:0] OP_BYTE  = 2'd0;
	localparam logic [OP_W-1:0] OP_TICK  = 2'd1;
	localparam logic [OP_W-1:0] OP_ABORT = 2'd2;

	// result kinds
	localparam logic [KIND_W-1:0] KIND_PAYLOAD = 3'd0;
	localparam logic [KIND_W-1:0] KIND_GOOD    = 3'd1;
	localparam logic [KIND_W-1:0] KIND_CRC_BAD = 3'd2;
	localparam logic [KIND_W-1:0] KIND_TOO_BIG = 3'd3;
	localparam logic [KIND_W-1:0] KIND_TIMEOUT = 3'd4;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_HEADER  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_LEN = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT = 2'd2;

	localparam logic [BYTE_W-1:0] HEADER_RST  = 8'hFF;
	localparam logic [LEN_W-1:0]  MAX_LEN_RST = 16'd448;
	localparam logic [TICK_W-1:0] TIMEOUT_RST = 32'd500;

	localparam logic [CRC_W-1:0] CRC_POLY = 16'h1021;
	localparam logic [CRC_W-1:0] CRC_INIT = 16'h0000;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [BYTE_W-1:0] command;
		logic [BYTE_W-1:0] payload_byte;
		logic [LEN_W-1:0]  payload_index;
		logic [LEN_W-1:0]  frame_length;
		logic [CRC_W-1:0]  received_check;
		logic [CRC_W-1:0]  computed_check;
	} c16d_result_t;

	typedef struct packed {
		logic [BYTE_W-1:0] header;
		logic [LEN_W-1:0]  max_len;
		logic [TICK_W-1:0] timeout;
	} c16d_cfg_t;

	// msb-first crc-16 update over one byte
	function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc_in,
			input logic [BYTE_W-1:0] data);
		logic [CRC_W-1:0] c;
		c = crc_in ^ {data, 8'h00};
		for (int k = 0; k < BYTE_W; k++) begin
			if (c[CRC_W-1])
				c = {c[CRC_W-2:0], 1'b0} ^ CRC_POLY;
			else
				c = {c[CRC_W-2:0], 1'b0};
		end
		return c;
	endfunction

endpackage
`default_nettype wire

// ----- design/c16d_if.sv -----
// stream interfaces: received request channel and result channel
`timescale 1ns / 1ps
`default_nettype none
interface c16d_req_if;
	import c16d_pkg::*;
	logic              valid;
	logic              ready;
	logic [OP_W-1:0]   op;
	logic [BYTE_W-1:0] byte_value;
	modport source (output valid, op, byte_value, input ready);
	modport sink (input valid, op, byte_value, output ready);
endinterface

interface c16d_rsp_if;
	import c16d_pkg::*;
	logic              valid;
	logic              ready;
	logic [KIND_W-1:0] kind;
	logic [BYTE_W-1:0] command;
	logic [BYTE_W-1:0] payload_byte;
	logic [LEN_W-1:0]  payload_index;
	logic [LEN_W-1:0]  frame_length;
	logic [CRC_W-1:0]  received_check;
	logic [CRC_W-1:0]  computed_check;
	modport source (output valid, kind, command, payload_byte, payload_index, frame_length,
		received_check, computed_check, input ready);
	modport sink (input valid, kind, command, payload_byte, payload_index, frame_length,
		received_check, computed_check, output ready);
endinterface
`default_nettype wire

// ----- design/crc16_packet_deframer.sv -----
// Length-prefixed frame deframer with CRC-16 (poly 0x1021, init 0) over the payload.
// Requests carry a received byte, a time tick or an abort. One request is taken every
// clock cycle unless a stalled result holds the flow; it sits in an input register,
// the parser then updates its state and the result register in a single pass, and a
// result is offered from the result register. A new request can enter the input
// register while an earlier result still waits; when that result stalls, at most one
// more request is held. Payload bytes leave as they arrive, and each frame past its
// length field ends in one status result unless it is aborted. Configuration writes
// take effect at the next edge and belong in idle periods only.
`timescale 1ns / 1ps
`default_nettype none
module crc16_packet_deframer (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	c16d_req_if.sink                             req,
	c16d_rsp_if.source                           rsp,
	input  wire logic                            cfg_wr_en,
	input  wire logic [c16d_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [c16d_pkg::CFG_W-1:0]      cfg_data
);
	import c16d_pkg::*;

	c16d_cfg_t         cfg_q;
	logic              valid_s1;
	logic [OP_W-1:0]   op_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic              advance;
	logic              res_valid;
	c16d_result_t      res;
	logic              out_valid_q;
	c16d_result_t      out_q;

	assign advance   = valid_s1 && (!out_valid_q || rsp.ready);
	assign req.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.header  <= HEADER_RST;
			cfg_q.max_len <= MAX_LEN_RST;
			cfg_q.timeout <= TIMEOUT_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_HEADER:  cfg_q.header  <= cfg_data[BYTE_W-1:0];
				REG_MAX_LEN: cfg_q.max_len <= cfg_data[LEN_W-1:0];
				REG_TIMEOUT: cfg_q.timeout <= cfg_data[TICK_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (req.ready)
			valid_s1 <= req.valid;
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			op_s1   <= req.op;
			byte_s1 <= req.byte_value;
		end
	end

	c16d_parser u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.step_en    (advance),
		.op         (op_s1),
		.byte_value (byte_s1),
		.cfg        (cfg_q),
		.res_valid  (res_valid),
		.res        (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (advance)
			out_valid_q <= res_valid;
		else if (rsp.ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (advance && res_valid)
			out_q <= res;
	end

	assign rsp.valid          = out_valid_q;
	assign rsp.kind           = out_q.kind;
	assign rsp.command        = out_q.command;
	assign rsp.payload_byte   = out_q.payload_byte;
	assign rsp.payload_index  = out_q.payload_index;
	assign rsp.frame_length   = out_q.frame_length;
	assign rsp.received_check = out_q.received_check;
	assign rsp.computed_check = out_q.computed_check;

	a_hold_stalled_request: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(op_s1) && $stable(byte_s1))
		else $error("held request lost while result stalled");

	a_payload_index: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.kind == KIND_PAYLOAD |-> rsp.payload_index < rsp.frame_length)
		else $error("payload index beyond frame length");

	a_good_matches: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.kind == KIND_GOOD |-> rsp.received_check == rsp.computed_check)
		else $error("good frame with differing checks");

	a_bad_differs: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.kind == KIND_CRC_BAD |-> rsp.received_check != rsp.computed_check)
		else $error("crc mismatch with equal checks");

endmodule
`default_nettype wire

// ----- design/c16d_parser.sv -----
// frame parser state machine with running crc and idle timer
`timescale 1ns / 1ps
`default_nettype none
module c16d_parser (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          step_en,
	input  wire logic [c16d_pkg::OP_W-1:0]     op,
	input  wire logic [c16d_pkg::BYTE_W-1:0]   byte_value,
	input  wire c16d_pkg::c16d_cfg_t           cfg,
	output logic                               res_valid,
	output c16d_pkg::c16d_result_t             res
);
	import c16d_pkg::*;

	localparam logic [2:0] PH_HEADER  = 3'd0;
	localparam logic [2:0] PH_COMMAND = 3'd1;
	localparam logic [2:0] PH_LEN_LO  = 3'd2;
	localparam logic [2:0] PH_LEN_HI  = 3'd3;
	localparam logic [2:0] PH_PAYLOAD = 3'd4;
	localparam logic [2:0] PH_CRC_LO  = 3'd5;
	localparam logic [2:0] PH_CRC_HI  = 3'd6;

	logic [2:0]        phase_q, phase_n, phase_eff;
	logic [BYTE_W-1:0] cmd_q, cmd_n;
	logic [LEN_W-1:0]  len_q, len_n;
	logic [LEN_W-1:0]  count_q, count_n;
	logic [BYTE_W-1:0] low_q, low_n;
	logic [CRC_W-1:0]  crc_q, crc_n;
	logic [TICK_W-1:0] idle_q, idle_n;
	logic [LEN_W-1:0]  count_inc;
	logic [LEN_W-1:0]  new_len;
	logic [CRC_W-1:0]  rx_check;

	assign count_inc = count_q + 1'b1;
	assign new_len   = {byte_value, low_q};
	assign rx_check  = {byte_value, low_q};

	always_comb begin
		phase_n   = phase_q;
		phase_eff = phase_q;
		cmd_n     = cmd_q;
		len_n     = len_q;
		count_n   = count_q;
		low_n     = low_q;
		crc_n     = crc_q;
		idle_n    = idle_q;
		res_valid = 1'b0;
		res       = '0;
		res.command      = cmd_q;
		res.frame_length = len_q;
		if (step_en) begin
			case (op)
				OP_TICK: begin
					if (idle_q != '1)
						idle_n = idle_q + 1'b1;
				end
				OP_ABORT: begin
					phase_n = PH_HEADER;
					idle_n  = '0;
				end
				OP_BYTE: begin
					// a stale frame is dropped, then the byte is hunted as a header
					if (phase_q != PH_HEADER && idle_q > cfg.timeout) begin
						res_valid = 1'b1;
						res.kind  = KIND_TIMEOUT;
						phase_eff = PH_HEADER;
					end
					idle_n = '0;
					case (phase_eff)
						PH_COMMAND: begin
							cmd_n   = byte_value;
							phase_n = PH_LEN_LO;
						end
						PH_LEN_LO: begin
							low_n   = byte_value;
							phase_n = PH_LEN_HI;
						end
						PH_LEN_HI: begin
							len_n = new_len;
							if (new_len > cfg.max_len) begin
								res_valid        = 1'b1;
								res.kind         = KIND_TOO_BIG;
								res.frame_length = new_len;
								phase_n          = PH_HEADER;
							end else if (new_len == '0) begin
								phase_n = PH_CRC_LO;
							end else begin
								count_n = '0;
								crc_n   = CRC_INIT;
								phase_n = PH_PAYLOAD;
							end
						end
						PH_PAYLOAD: begin
							res_valid         = 1'b1;
							res.kind          = KIND_PAYLOAD;
							res.payload_byte  = byte_value;
							res.payload_index = count_q;
							crc_n             = crc_byte(crc_q, byte_value);
							count_n           = count_inc;
							if (count_inc >= len_q)
								phase_n = PH_CRC_LO;
						end
						PH_CRC_LO: begin
							low_n   = byte_value;
							phase_n = PH_CRC_HI;
						end
						PH_CRC_HI: begin
							res_valid          = 1'b1;
							res.kind           = (rx_check == crc_q) ? KIND_GOOD : KIND_CRC_BAD;
							res.received_check = rx_check;
							res.computed_check = crc_q;
							phase_n            = PH_HEADER;
						end
						default: begin
							phase_n = PH_HEADER;
							if (byte_value == cfg.header) begin
								phase_n = PH_COMMAND;
								cmd_n   = '0;
								len_n   = '0;
								count_n = '0;
								crc_n   = CRC_INIT;
							end
						end
					endcase
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HEADER;
			cmd_q   <= '0;
			len_q   <= '0;
			count_q <= '0;
			low_q   <= '0;
			crc_q   <= CRC_INIT;
			idle_q  <= '0;
		end else begin
			phase_q <= phase_n;
			cmd_q   <= cmd_n;
			len_q   <= len_n;
			count_q <= count_n;
			low_q   <= low_n;
			crc_q   <= crc_n;
			idle_q  <= idle_n;
		end
	end

	a_phase_legal: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q != 3'd7)
		else $error("parser phase reached unused code");

	a_payload_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_PAYLOAD |-> count_q < len_q)
		else $error("payload count ran past declared length");

	a_idle_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		step_en && op == OP_BYTE |=> idle_q == '0)
		else $error("idle timer not cleared by a byte");

endmodule
`default_nettype wire

// ----- tb/tb_crc16_packet_deframer.sv -----
// testbench for the crc-16 frame deframer: directed and random byte streams checked against an inline parser
`timescale 1ns / 1ps
module tb_crc16_packet_deframer;
	import c16d_pkg::*;

	localparam logic [OP_W-1:0] OP_SPARE = 2'd3;
	localparam int HOLD_CYCLES = 300;
	localparam int QUIET_LIMIT = 4000;
	localparam int PHASE_ITEMS = 480;

	typedef enum logic [2:0] {
		P_HUNT, P_CMD, P_LEN_LO, P_LEN_HI, P_DATA, P_CRC_LO, P_CRC_HI
	} parse_phase_e;

	typedef struct packed {
		logic [OP_W-1:0]   op;
		logic [BYTE_W-1:0] value;
	} line_event_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wr_en;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0] cfg_data;

	c16d_req_if req_ch();
	c16d_rsp_if rsp_ch();

	crc16_packet_deframer u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// register copies and parser state
	logic [BYTE_W-1:0] hdr_cfg;
	logic [LEN_W-1:0]  max_len_cfg;
	logic [TICK_W-1:0] timeout_cfg;
	parse_phase_e      ph;
	logic [BYTE_W-1:0] frame_cmd;
	logic [LEN_W-1:0]  decl_len;
	logic [LEN_W-1:0]  data_count;
	logic [BYTE_W-1:0] low_hold;
	logic [CRC_W-1:0]  crc_acc;
	logic [TICK_W-1:0] idle_ticks;

	c16d_result_t parsed_q[$];
	line_event_t  line_events_q[$];

	int send_idle_pct = 0;
	int stall_pct = 0;
	int item_count = 0;
	int mismatches = 0;
	int quiet = 0;
	int hold_cnt = 0;
	logic long_hold_req = 1'b0;
	logic hold_done = 1'b0;
	logic req_taken = 1'b0;
	line_event_t drv_item;
	line_event_t mon_item;
	c16d_result_t got_res;
	c16d_result_t want_res;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic logic [CRC_W-1:0] crc16_step(input logic [CRC_W-1:0] crc,
			input logic [BYTE_W-1:0] d);
		logic [CRC_W-1:0] c;
		logic fb;
		c = crc;
		for (int i = BYTE_W - 1; i >= 0; i--) begin
			fb = c[CRC_W-1] ^ d[i];
			c = {c[CRC_W-2:0], 1'b0};
			if (fb)
				c = c ^ CRC_POLY;
		end
		return c;
	endfunction

	function automatic string fmt_result(input c16d_result_t r);
		return $sformatf("kind %0d cmd %02h byte %02h idx %0d len %0d rx %04h calc %04h",
			r.kind, r.command, r.payload_byte, r.payload_index, r.frame_length,
			r.received_check, r.computed_check);
	endfunction

	task automatic push_parsed(input logic [KIND_W-1:0] kind, input logic [BYTE_W-1:0] pb,
			input logic [LEN_W-1:0] pidx, input logic [CRC_W-1:0] rxc,
			input logic [CRC_W-1:0] cc);
		c16d_result_t r;
		r.kind = kind;
		r.command = frame_cmd;
		r.payload_byte = pb;
		r.payload_index = pidx;
		r.frame_length = decl_len;
		r.received_check = rxc;
		r.computed_check = cc;
		parsed_q.push_back(r);
	endtask

	task automatic deframe_step(input line_event_t it);
		logic [CRC_W-1:0] rx;
		case (it.op)
			OP_TICK: begin
				if (idle_ticks != '1)
					idle_ticks = idle_ticks + 1'b1;
			end
			OP_ABORT: begin
				ph = P_HUNT;
				idle_ticks = '0;
			end
			OP_BYTE: begin
				// a stale frame is dropped, then the byte is hunted
				if (ph != P_HUNT && idle_ticks > timeout_cfg) begin
					push_parsed(KIND_TIMEOUT, '0, '0, '0, '0);
					ph = P_HUNT;
				end
				idle_ticks = '0;
				case (ph)
					P_CMD: begin
						frame_cmd = it.value;
						ph = P_LEN_LO;
					end
					P_LEN_LO: begin
						low_hold = it.value;
						ph = P_LEN_HI;
					end
					P_LEN_HI: begin
						decl_len = {it.value, low_hold};
						if (decl_len > max_len_cfg) begin
							push_parsed(KIND_TOO_BIG, '0, '0, '0, '0);
							ph = P_HUNT;
						end else if (decl_len == '0) begin
							ph = P_CRC_LO;
						end else begin
							data_count = '0;
							crc_acc = CRC_INIT;
							ph = P_DATA;
						end
					end
					P_DATA: begin
						push_parsed(KIND_PAYLOAD, it.value, data_count, '0, '0);
						crc_acc = crc16_step(crc_acc, it.value);
						data_count = data_count + 1'b1;
						if (data_count >= decl_len)
							ph = P_CRC_LO;
					end
					P_CRC_LO: begin
						low_hold = it.value;
						ph = P_CRC_HI;
					end
					P_CRC_HI: begin
						rx = {it.value, low_hold};
						push_parsed((rx == crc_acc) ? KIND_GOOD : KIND_CRC_BAD, '0, '0, rx, crc_acc);
						ph = P_HUNT;
					end
					default: begin
						ph = P_HUNT;
						if (it.value == hdr_cfg) begin
							ph = P_CMD;
							frame_cmd = '0;
							decl_len = '0;
							data_count = '0;
							crc_acc = CRC_INIT;
						end
					end
				endcase
			end
			default: ;
		endcase
	endtask

	task automatic add_item(input logic [OP_W-1:0] op, input logic [BYTE_W-1:0] v);
		line_event_t it;
		it.op = op;
		it.value = v;
		line_events_q.push_back(it);
		if (op != OP_SPARE)
			item_count++;
	endtask

	task automatic add_ticks(input int n);
		repeat (n) add_item(OP_TICK, $urandom_range(255));
	endtask

	task automatic add_gap(input int tick_max);
		if (tick_max > 0 && $urandom_range(3) == 0)
			add_ticks($urandom_range(1, tick_max));
	endtask

	// fill < 0 gives random payload bytes
	task automatic add_frame(input logic [BYTE_W-1:0] cmd, input int len, input bit bad_crc,
			input int tick_max, input int fill);
		logic [CRC_W-1:0] c;
		logic [BYTE_W-1:0] d;
		c = CRC_INIT;
		add_item(OP_BYTE, hdr_cfg);
		add_gap(tick_max);
		add_item(OP_BYTE, cmd);
		add_gap(tick_max);
		add_item(OP_BYTE, len[7:0]);
		add_gap(tick_max);
		add_item(OP_BYTE, len[15:8]);
		if (len <= max_len_cfg) begin
			for (int k = 0; k < len; k++) begin
				d = (fill < 0) ? BYTE_W'($urandom_range(255)) : fill[7:0];
				add_gap(tick_max);
				add_item(OP_BYTE, d);
				c = crc16_step(c, d);
			end
			if (bad_crc)
				c = c ^ CRC_W'($urandom_range(1, 16'hFFFF));
			add_gap(tick_max);
			add_item(OP_BYTE, c[7:0]);
			add_gap(tick_max);
			add_item(OP_BYTE, c[15:8]);
		end
	endtask

	task automatic random_traffic(input int target, input int tick_max);
		int r;
		int lim;
		item_count = 0;
		while (item_count < target) begin
			r = $urandom_range(99);
			if (r < 55) begin
				lim = (max_len_cfg < 8) ? max_len_cfg : 8;
				add_frame($urandom_range(255), $urandom_range(0, lim),
					$urandom_range(99) < 15, tick_max, -1);
			end else if (r < 65) begin
				lim = (max_len_cfg < 40) ? max_len_cfg : 40;
				add_frame($urandom_range(255), $urandom_range(0, lim),
					$urandom_range(99) < 15, tick_max, -1);
			end else if (r < 73) begin
				if (max_len_cfg != 16'hFFFF)
					add_frame($urandom_range(255), $urandom_range(max_len_cfg + 1, 16'hFFFF),
						1'b0, tick_max, -1);
			end else if (r < 83) begin
				repeat ($urandom_range(1, 3)) add_item(OP_BYTE, $urandom_range(255));
			end else if (r < 90) begin
				// frame cut short by an abort
				add_item(OP_BYTE, hdr_cfg);
				repeat ($urandom_range(0, 3)) add_item(OP_BYTE, $urandom_range(255));
				add_item(OP_ABORT, $urandom_range(255));
			end else if (r < 96) begin
				add_ticks($urandom_range(1, tick_max + 2));
			end else begin
				add_item(OP_SPARE, $urandom_range(255));
			end
		end
	endtask

	task automatic set_config(input logic [BYTE_W-1:0] h, input logic [LEN_W-1:0] m,
			input logic [TICK_W-1:0] t);
		cfg_wr_en <= 1'b1;
		cfg_index <= REG_HEADER;
		cfg_data <= CFG_W'(h);
		@(negedge clk);
		cfg_index <= REG_MAX_LEN;
		cfg_data <= CFG_W'(m);
		@(negedge clk);
		cfg_index <= REG_TIMEOUT;
		cfg_data <= CFG_W'(t);
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		hdr_cfg = h;
		max_len_cfg = m;
		timeout_cfg = t;
	endtask

	task automatic drain();
		while (line_events_q.size() != 0 || req_ch.valid)
			@(negedge clk);
		while (parsed_q.size() != 0)
			@(negedge clk);
		// requests that give no result may still be in the pipe
		repeat (4) @(negedge clk);
	endtask

	// request driver
	always @(negedge clk) begin
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
		end else if (!req_ch.valid || req_taken) begin
			if (line_events_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				drv_item = line_events_q.pop_front();
				req_ch.valid <= 1'b1;
				req_ch.op <= drv_item.op;
				req_ch.byte_value <= drv_item.value;
			end else begin
				req_ch.valid <= 1'b0;
			end
		end
	end

	// result receiver with one long hold-off
	always @(negedge clk) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
		end else if (long_hold_req && !hold_done) begin
			rsp_ch.ready <= 1'b0;
			hold_cnt <= hold_cnt + 1;
			if (hold_cnt == HOLD_CYCLES - 1)
				hold_done <= 1'b1;
		end else begin
			rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	// monitor
	always @(posedge clk) begin
		if (!arst_n) begin
			req_taken <= 1'b0;
		end else begin
			req_taken <= req_ch.valid && req_ch.ready;
			if (req_ch.valid && req_ch.ready) begin
				mon_item.op = req_ch.op;
				mon_item.value = req_ch.byte_value;
				deframe_step(mon_item);
			end
			if (rsp_ch.valid && rsp_ch.ready) begin
				got_res.kind = rsp_ch.kind;
				got_res.command = rsp_ch.command;
				got_res.payload_byte = rsp_ch.payload_byte;
				got_res.payload_index = rsp_ch.payload_index;
				got_res.frame_length = rsp_ch.frame_length;
				got_res.received_check = rsp_ch.received_check;
				got_res.computed_check = rsp_ch.computed_check;
				if (parsed_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result: %s", fmt_result(got_res));
				end else begin
					want_res = parsed_q.pop_front();
					if (got_res.kind !== want_res.kind
							|| got_res.command !== want_res.command
							|| got_res.payload_byte !== want_res.payload_byte
							|| got_res.payload_index !== want_res.payload_index
							|| got_res.frame_length !== want_res.frame_length
							|| got_res.received_check !== want_res.received_check
							|| got_res.computed_check !== want_res.computed_check) begin
						mismatches++;
						if (mismatches <= 10) begin
							$display("mismatch at %0t", $realtime);
							$display("  expected %s", fmt_result(want_res));
							$display("  actual   %s", fmt_result(got_res));
						end
					end
				end
			end
		end
	end

	// watchdog on cycles with no handshake at all
	always @(posedge clk) begin
		if (!arst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
			quiet <= 0;
		end else if (quiet >= QUIET_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end else begin
			quiet <= quiet + 1;
		end
	end

	initial begin
		req_ch.valid = 1'b0;
		req_ch.op = OP_BYTE;
		req_ch.byte_value = '0;
		rsp_ch.ready = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = REG_HEADER;
		cfg_data = '0;
		hdr_cfg = HEADER_RST;
		max_len_cfg = MAX_LEN_RST;
		timeout_cfg = TIMEOUT_RST;
		ph = P_HUNT;
		frame_cmd = '0;
		decl_len = '0;
		data_count = '0;
		low_hold = '0;
		crc_acc = CRC_INIT;
		idle_ticks = '0;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// default settings, no idling
		set_config(8'hFF, MAX_LEN_RST, TIMEOUT_RST);
		add_item(OP_BYTE, 8'h00);
		add_item(OP_SPARE, 8'hFF);
		add_item(OP_TICK, 8'h00);
		add_frame(8'h00, 0, 1'b0, 0, -1);
		add_frame(8'hFF, 1, 1'b0, 0, 8'hFF);
		add_frame(8'h3C, 0, 1'b1, 0, -1);
		add_frame(8'h5A, 449, 1'b0, 0, -1);
		add_item(OP_BYTE, hdr_cfg);
		add_item(OP_BYTE, 8'h11);
		add_item(OP_ABORT, 8'h00);
		add_item(OP_BYTE, 8'h22);
		random_traffic(PHASE_ITEMS, 4);
		drain();

		// zero header, zero max length, zero timeout; sender idles
		set_config(8'h00, 16'h0000, 32'h0000_0000);
		send_idle_pct = 56;
		add_item(OP_BYTE, hdr_cfg);
		add_item(OP_TICK, 8'hFF);
		add_item(OP_BYTE, 8'h44);
		add_item(OP_BYTE, hdr_cfg);
		add_item(OP_BYTE, 8'h99);
		add_item(OP_BYTE, 8'h01);
		add_item(OP_TICK, 8'h00);
		add_item(OP_BYTE, 8'h00);
		add_frame(8'hC3, 1, 1'b0, 0, -1);
		random_traffic(PHASE_ITEMS, 2);
		drain();

		// widest limits; receiver stalls and holds off once
		set_config(8'h7E, 16'hFFFF, 32'hFFFF_FFFF);
		send_idle_pct = 0;
		stall_pct = 56;
		add_item(OP_BYTE, hdr_cfg);
		add_item(OP_BYTE, 8'h81);
		add_item(OP_BYTE, 8'hFF);
		add_item(OP_BYTE, 8'hFF);
		repeat (3) add_item(OP_BYTE, $urandom_range(255));
		add_item(OP_ABORT, 8'h00);
		random_traffic(PHASE_ITEMS, 4);
		long_hold_req = 1'b1;
		drain();

		// short frames, timeout of one tick; both sides idle
		set_config(8'hA5, 16'd6, 32'd1);
		send_idle_pct = 17;
		stall_pct = 17;
		random_traffic(PHASE_ITEMS, 3);
		drain();

		if (mismatches == 0 && parsed_q.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
